[hw/rtl/lmphd_pkg.sv]
// Package for the LED level meter with peak hold and decay.
// Holds the field widths, display mode codes, register indexes and the hold
// time and LED pattern functions. It depends on nothing else.
package lmphd_pkg;

  localparam int LED_COUNT  = 9;
  localparam int CHANNELS   = 2;
  localparam int LVL_W      = 4;
  localparam int CHAN_W     = 1;
  localparam int TIME_W     = 16;
  localparam int PEAK_W     = 5;
  localparam int HOLD_IDX_W = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam int HOLD_STEPS   = 12;
  localparam int HOLD_BASE_MS = 200;
  localparam int HOLD_STEP_MS = 250;

  localparam logic signed [PEAK_W-1:0] PEAK_NONE = {PEAK_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_DOT   = 2'd1,
    MODE_BAR   = 2'd2,
    MODE_SOLID = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_INDEX   = 1'd1;

  // Hold time in milliseconds; indexes past the last step use the last step.
  function automatic logic [TIME_W-1:0] hold_ms(input logic [HOLD_IDX_W-1:0] idx);
    int sel;
    sel = (int'(idx) >= HOLD_STEPS) ? (HOLD_STEPS - 1) : int'(idx);
    return TIME_W'(HOLD_BASE_MS + HOLD_STEP_MS * sel);
  endfunction

  // Dot lights only the peak LED, bar lights every LED up to the peak.
  // A peak of none gives a dark display.
  function automatic logic [LED_COUNT-1:0] peak_pattern(
      input mode_t                    mode,
      input logic signed [PEAK_W-1:0] peak);
    logic [LED_COUNT-1:0]      pat;
    logic signed [PEAK_W:0]    pos;
    logic signed [PEAK_W:0]    peak_x;
    pat    = '0;
    peak_x = signed'({peak[PEAK_W-1], peak});
    for (int i = 0; i < LED_COUNT; i++) begin
      pos = signed'((PEAK_W + 1)'(i));
      if (mode == MODE_DOT) begin
        pat[i] = (pos == peak_x);
      end else begin
        pat[i] = (pos <= peak_x);
      end
    end
    return pat;
  endfunction

endpackage

[hw/rtl/led_meter_peak_hold_decay_top.sv]
// Top level of the LED level meter with peak hold and decay.
// Holds the per-channel peak state, the configuration registers and the
// output register with its skid stage. It depends on lmphd_pkg.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | in_level, in_chan, in_time_ms
//  out     | out_valid / out_stall| out_chan, out_led_pattern, out_held_peak
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A beat is taken every cycle unless the input stalls. Its result, if any,
// is registered into the output register or the skid stage; the peak update
// for its channel lands in the same edge, so the next beat on either channel sees it.
// Synchronous active-low reset sets every peak to none, every timer to zero,
// the mode to bar and the hold index to zero, and empties the output side.
// A stalled output keeps one more result in the skid stage; the input stalls
// only while that stage is full. The configuration port is always ready.
module led_meter_peak_hold_decay_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lmphd_pkg::LVL_W-1:0]        in_level,
  input  logic [lmphd_pkg::CHAN_W-1:0]       in_chan,
  input  logic [lmphd_pkg::TIME_W-1:0]       in_time_ms,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lmphd_pkg::CHAN_W-1:0]       out_chan,
  output logic [lmphd_pkg::LED_COUNT-1:0]    out_led_pattern,
  output logic signed [lmphd_pkg::PEAK_W-1:0] out_held_peak,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lmphd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lmphd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lmphd_pkg::*;

  // Configuration registers.
  mode_t                  display_mode_r;
  logic [HOLD_IDX_W-1:0]  hold_index_r;

  // Per-channel peak state.
  logic signed [PEAK_W-1:0] peak_level_r [CHANNELS];
  logic [TIME_W-1:0]        peak_time_r  [CHANNELS];

  // Output register and skid stage.
  logic                     out_valid_r;
  logic [CHAN_W-1:0]        out_chan_r;
  logic [LED_COUNT-1:0]     out_pat_r;
  logic signed [PEAK_W-1:0] out_peak_r;
  logic                     skid_valid_r;
  logic [CHAN_W-1:0]        skid_chan_r;
  logic [LED_COUNT-1:0]     skid_pat_r;
  logic signed [PEAK_W-1:0] skid_peak_r;

  logic                     in_fire;
  logic                     out_fire;
  logic                     out_free;
  logic                     chan_ok;
  logic [LVL_W-1:0]         lvl_sat;
  logic signed [PEAK_W-1:0] lvl_s;
  logic signed [PEAK_W-1:0] cur_peak;
  logic [TIME_W-1:0]        elapsed;
  logic                     hold_done;
  logic                     res_valid;
  logic                     upd_state;
  logic signed [PEAK_W-1:0] peak_nxt;
  logic [LED_COUNT-1:0]     pat_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_free  = out_fire || !out_valid_r;

  assign out_valid       = out_valid_r;
  assign out_chan        = out_chan_r;
  assign out_led_pattern = out_pat_r;
  assign out_held_peak   = out_peak_r;

  // The work for one beat: saturate the level, in dot and bar modes compare
  // against the held peak and check the hold timer, and form the pattern.
  always_comb begin
    chan_ok  = (int'(in_chan) < CHANNELS);
    lvl_sat  = (int'(in_level) > LED_COUNT - 1) ? LVL_W'(LED_COUNT - 1) : in_level;
    lvl_s    = signed'(PEAK_W'(lvl_sat));
    cur_peak = peak_level_r[in_chan];
    elapsed  = in_time_ms - peak_time_r[in_chan];
    hold_done = (elapsed >= hold_ms(hold_index_r));
    peak_nxt  = cur_peak;
    pat_nxt   = '0;
    res_valid = 1'b0;
    upd_state = 1'b0;
    case (display_mode_r)
      MODE_OFF: begin
        res_valid = chan_ok;
      end
      MODE_SOLID: begin
        pat_nxt   = '1;
        res_valid = chan_ok;
      end
      MODE_DOT, MODE_BAR: begin
        if (lvl_s >= cur_peak) begin
          peak_nxt  = lvl_s;
          res_valid = chan_ok;
          upd_state = chan_ok;
        end else if (hold_done) begin
          // Decay by one step, but never below none.
          peak_nxt  = (cur_peak == PEAK_NONE) ? PEAK_NONE : cur_peak - PEAK_W'(1);
          res_valid = chan_ok;
          upd_state = chan_ok;
        end
        pat_nxt = (peak_nxt[PEAK_W-1]) ? '0 : peak_pattern(display_mode_r, peak_nxt);
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Control state: configuration, peak state and output occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_mode_r <= MODE_BAR;
      hold_index_r   <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        peak_level_r[c] <= PEAK_NONE;
        peak_time_r[c]  <= '0;
      end
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DISPLAY_MODE: display_mode_r <= mode_t'(cfg_data[1:0]);
          CFG_HOLD_INDEX:   hold_index_r   <= cfg_data;
          default:          hold_index_r   <= hold_index_r;
        endcase
      end
      if (in_fire && upd_state) begin
        peak_level_r[in_chan] <= peak_nxt;
        peak_time_r[in_chan]  <= in_time_ms;
      end
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_fire && res_valid;
        end
      end else if (in_fire && res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_chan_r <= skid_chan_r;
        out_pat_r  <= skid_pat_r;
        out_peak_r <= skid_peak_r;
      end else begin
        out_chan_r <= in_chan;
        out_pat_r  <= pat_nxt;
        out_peak_r <= peak_nxt;
      end
    end else if (in_fire && res_valid) begin
      skid_chan_r <= in_chan;
      skid_pat_r  <= pat_nxt;
      skid_peak_r <= peak_nxt;
    end
  end

  // The skid stage only ever holds a result behind a waiting output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full while output register empty");

  // A result arriving behind a stalled output must land in the skid stage.
  a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && in_fire && res_valid) |=> skid_valid_r)
    else $error("result lost behind a stalled output");

  // A held peak is never below none nor above the top LED.
  a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_peak_r >= PEAK_NONE) &&
                    (out_peak_r <= signed'(PEAK_W'(LED_COUNT - 1))))
    else $error("held peak out of range");

  // A peak of none always shows a dark display unless the mode is solid.
  a_none_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_peak_r == PEAK_NONE) && (display_mode_r != MODE_SOLID))
      |-> (out_pat_r == '0))
    else $error("pattern lit with no held peak");

endmodule
